### rtl/ips_pkg.sv
// Package for the interrupt priority selector.
// Holds sizes, request and register codes, the IRL code table and the scan word type.
// Used by ips_cell and interrupt_priority_select.
package ips_pkg;

	localparam int NUM_LINES = 16;
	localparam int IRL_BASE  = NUM_LINES - 4;
	localparam int CODE_W    = 12;
	localparam int PRIO_W    = 4;
	localparam int LINE_W    = 4;
	localparam int CNT_W     = $clog2(NUM_LINES);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [1:0] {
		REQ_SET_LINE = 2'd0,
		REQ_SET_IRL  = 2'd1,
		REQ_CHECK    = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IPR_A     = 3'd0,
		REG_IPR_B     = 3'd1,
		REG_IPR_C     = 3'd2,
		REG_IPR_D     = 3'd3,
		REG_INDEP_IRL = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

	// Best candidate so far, handed from cell to cell along the scan.
	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [LINE_W-1:0] line;
		logic [CODE_W-1:0] code;
	} cand_t;

	// Code stored for a low IRL pin k.
	function automatic logic [CODE_W-1:0] irl_code(input logic [1:0] k);
		logic [CODE_W-1:0] c;
		begin
			case (k)
				2'd0:    c = 12'h240;
				2'd1:    c = 12'h2A0;
				2'd2:    c = 12'h300;
				default: c = 12'h360;
			endcase
			return c;
		end
	endfunction

endpackage

### rtl/ips_cell.sv
// One line cell of the interrupt priority selector.
// Holds the pending code of its line and updates the scan word passing through it.
// Depends on ips_pkg.
module ips_cell
	import ips_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CODE_W-1:0] wr_data,
	input  logic [LINE_W-1:0] line_id,
	input  logic [PRIO_W-1:0] prio,
	input  logic [PRIO_W-1:0] mask,
	input  logic              scan_en,
	input  cand_t             cand_in,
	output cand_t             cand_out,
	output logic [CODE_W-1:0] code
);

	logic [CODE_W-1:0] code_q;
	cand_t             cand_q;
	logic              hit;

	// Strictly greater keeps the lower line on a tie.
	assign hit = scan_en && (code_q != '0) && (prio > mask)
		&& (!cand_in.valid || (prio > cand_in.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			cand_q <= '0;
		end else begin
			if (wr_en) begin
				code_q <= wr_data;
			end
			if (hit) begin
				cand_q.valid <= 1'b1;
				cand_q.prio  <= prio;
				cand_q.line  <= line_id;
				cand_q.code  <= code_q;
			end else begin
				cand_q <= cand_in;
			end
		end
	end

	assign cand_out = cand_q;
	assign code     = code_q;

endmodule

### rtl/interrupt_priority_select.sv
// Top level of the interrupt priority selector.
// Sequencer, configuration registers and the row of line cells.
// Depends on ips_pkg and ips_cell.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// A set-line or set-IRL item is written at that edge and produces no result;
// busy stays low, so another item may follow in the next cycle.
// A check item with block_bit or in_delay_slot set returns an all-zero result
// in the next cycle and holds busy low.
// Any other check holds busy through the scan and finish states: the scan word
// walks the row of line cells, one cell per cycle, then the finish state merges
// the IRL level and clears the served line(s). The result is registered from the
// finish state and shows on the result ports with done high for exactly one cycle.
// The receiver cannot stall; results are not held.
// Configuration is written through cfg_we/cfg_index/cfg_data at any edge with
// cfg_we high; indexes beyond the register list are dropped.
// Reset clears all line codes, the priority registers and the IRL mode,
// and leaves the block idle.
module interrupt_priority_select
	import ips_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [LINE_W-1:0]    line_index,
	input  logic [CODE_W-1:0]    event_code_in,
	input  logic [3:0]           irl_pins,
	input  logic [PRIO_W-1:0]    interrupt_mask,
	input  logic                 block_bit,
	input  logic                 in_delay_slot,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output logic                 taken,
	output logic [CODE_W-1:0]    event_code,
	output logic [PRIO_W-1:0]    priority_res,
	output logic                 from_irl_bus,
	output logic [LINE_W-1:0]    source_line
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [PRIO_W-1:0] mask_q;
	logic [15:0]       ipr_q [4];
	logic              indep_q;

	logic              accept;
	logic              blocked;
	req_t              req;

	cand_t             chain [NUM_LINES+1];
	logic [CODE_W-1:0] cell_code [NUM_LINES];
	logic              cell_we [NUM_LINES];
	logic [CODE_W-1:0] cell_wd [NUM_LINES];

	logic [3:0]        irl_bits;
	logic              irl_win;
	logic              line_win;
	logic              scan_start;

	logic              done_q, taken_q, from_irl_q;
	logic [CODE_W-1:0] code_q;
	logic [PRIO_W-1:0] prio_q;
	logic [LINE_W-1:0] line_q;

	assign req     = req_t'(req_type);
	assign accept  = start && (state_q == ST_IDLE);
	assign blocked = block_bit || in_delay_slot;
	assign busy    = (state_q != ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipr_q[0] <= '0;
			ipr_q[1] <= '0;
			ipr_q[2] <= '0;
			ipr_q[3] <= '0;
			indep_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IPR_A:     ipr_q[0] <= cfg_data;
				REG_IPR_B:     ipr_q[1] <= cfg_data;
				REG_IPR_C:     ipr_q[2] <= cfg_data;
				REG_IPR_D:     ipr_q[3] <= cfg_data;
				REG_INDEP_IRL: indep_q  <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Sequencer
	assign scan_start = accept && (req == REQ_CHECK) && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mask_q  <= '0;
		end else begin
			state_q <= state_d;
			if (scan_start) begin
				mask_q <= interrupt_mask;
				cnt_q  <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (scan_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(NUM_LINES - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Merge the scan result with the encoded IRL level.
	// The level's priority is 15 - ~bits, which is the pending bit pattern itself.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			irl_bits[k] = (cell_code[IRL_BASE + k] != '0);
		end
	end

	assign irl_win = !indep_q && (irl_bits != '0) && (irl_bits > mask_q)
		&& (!chain[NUM_LINES].valid || (irl_bits > chain[NUM_LINES].prio));
	assign line_win = !irl_win && chain[NUM_LINES].valid;

	// Cell write controls: set items, IRL samples and serve clears.
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			cell_we[i] = 1'b0;
			cell_wd[i] = '0;
			if (accept && (req == REQ_SET_LINE)
				&& ({1'b0, line_index} < (LINE_W+1)'(NUM_LINES))
				&& (line_index == LINE_W'(i))) begin
				cell_we[i] = 1'b1;
				cell_wd[i] = event_code_in;
			end
			if (accept && (req == REQ_SET_IRL) && (i >= IRL_BASE)) begin
				cell_we[i] = 1'b1;
				cell_wd[i] = irl_pins[i - IRL_BASE] ? '0 : irl_code(2'(i - IRL_BASE));
			end
			if (state_q == ST_FINISH) begin
				if ((irl_win && (i >= IRL_BASE))
					|| (line_win && (chain[NUM_LINES].line == LINE_W'(i)))) begin
					cell_we[i] = 1'b1;
					cell_wd[i] = '0;
				end
			end
		end
	end

	// Row of line cells
	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
		logic include_w;

		assign include_w = (i < IRL_BASE) ? 1'b1 : indep_q;

		ips_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (cell_we[i]),
			.wr_data  (cell_wd[i]),
			.line_id  (LINE_W'(i)),
			.prio     (ipr_q[i >> 2][4 * (i & 3) +: 4]),
			.mask     (mask_q),
			.scan_en  (include_w),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.code     (cell_code[i])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH)
				|| (accept && (req == REQ_CHECK) && blocked);
		end
	end

	always_ff @(posedge clk) begin
		taken_q    <= 1'b0;
		from_irl_q <= 1'b0;
		code_q     <= '0;
		prio_q     <= '0;
		line_q     <= '0;
		if (state_q == ST_FINISH) begin
			if (irl_win) begin
				taken_q    <= 1'b1;
				from_irl_q <= 1'b1;
				code_q     <= 12'h200 + {3'b000, ~irl_bits, 5'b00000};
				prio_q     <= irl_bits;
			end else if (line_win) begin
				taken_q <= 1'b1;
				code_q  <= chain[NUM_LINES].code;
				prio_q  <= chain[NUM_LINES].prio;
				line_q  <= chain[NUM_LINES].line;
			end
		end
	end

	assign done         = done_q;
	assign taken        = taken_q;
	assign event_code   = code_q;
	assign priority_res = prio_q;
	assign from_irl_bus = from_irl_q;
	assign source_line  = line_q;

endmodule

### sim/interrupt_priority_select_tb.sv
// Self-checking testbench for interrupt_priority_select: directed table, then random words.
// Predicts every check against its own copy of line codes and priority registers.
// Depends on ips_pkg and the interrupt_priority_select RTL.
module interrupt_priority_select_tb;
	import ips_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_ITEMS   = 600;
	localparam int RAND_PHASES  = 6;
	localparam int DRAIN_CYCLES = 25;

	// Code stored for a low IRL pin, pin 0 in the low slice.
	localparam logic [3:0][CODE_W-1:0] PIN_CODE = {12'h360, 12'h300, 12'h2A0, 12'h240};

	typedef struct packed {
		req_t              req;
		logic [LINE_W-1:0] line;
		logic [CODE_W-1:0] code;
		logic [3:0]        pins;
		logic [PRIO_W-1:0] mask;
		logic              blk;
		logic              ds;
	} irq_word_t;

	typedef struct packed {
		logic              taken;
		logic [CODE_W-1:0] code;
		logic [PRIO_W-1:0] prio;
		logic              irl;
		logic [LINE_W-1:0] line;
	} irq_result_t;

	typedef struct {
		bit          is_reg;
		irq_word_t   word;
		bit          typed;
		irq_result_t want;
		cfg_reg_t    reg_idx;
		logic [15:0] reg_data;
	} dir_row_t;

	localparam irq_result_t NO_IRQ  = '0;
	localparam irq_result_t IRL_TOP = {1'b1, 12'h200, 4'd15, 1'b1, 4'd0};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           req_type;
	logic [LINE_W-1:0]    line_index;
	logic [CODE_W-1:0]    event_code_in;
	logic [3:0]           irl_pins;
	logic [PRIO_W-1:0]    interrupt_mask;
	logic                 block_bit;
	logic                 in_delay_slot;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	logic                 taken;
	logic [CODE_W-1:0]    event_code;
	logic [PRIO_W-1:0]    priority_res;
	logic                 from_irl_bus;
	logic [LINE_W-1:0]    source_line;

	interrupt_priority_select dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .line_index(line_index), .event_code_in(event_code_in),
		.irl_pins(irl_pins), .interrupt_mask(interrupt_mask), .block_bit(block_bit),
		.in_delay_slot(in_delay_slot), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .taken(taken), .event_code(event_code),
		.priority_res(priority_res), .from_irl_bus(from_irl_bus), .source_line(source_line)
	);

	// Predictor state
	logic [CODE_W-1:0] pend_code [NUM_LINES];
	logic [15:0]       prio_reg [4];
	bit                irl_indep;

	irq_result_t pending_irqs [$];
	dir_row_t    dir_rows [$];

	int          errors;
	int          cycles;
	int          words_sent;
	int          results_seen;
	int          taken_seen;
	int          irl_wins;
	int          settings_used;
	irq_result_t got;
	irq_result_t want;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time, pending_irqs.size());
			$display("interrupt_priority_select test failed");
			$finish;
		end
	end

	function automatic void cmp_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			got = {taken, event_code, priority_res, from_irl_bus, source_line};
			if (pending_irqs.size() == 0) begin
				$display("%0t: unexpected result, expected none actual 0x%0h", $time, got);
				errors++;
			end else begin
				want = pending_irqs.pop_front();
				cmp_field("taken", 32'(want.taken), 32'(got.taken));
				cmp_field("event_code", 32'(want.code), 32'(got.code));
				cmp_field("priority_res", 32'(want.prio), 32'(got.prio));
				cmp_field("from_irl_bus", 32'(want.irl), 32'(got.irl));
				cmp_field("source_line", 32'(want.line), 32'(got.line));
			end
			results_seen++;
			if (got.taken) taken_seen++;
			if (got.taken && got.irl) irl_wins++;
		end
	end

	function automatic logic [PRIO_W-1:0] line_prio(input int ln);
		return prio_reg[ln >> 2][(ln & 3) * 4 +: 4];
	endfunction

	// Apply one word to the predicted state; return 1 with the outcome when it makes a result.
	function automatic bit serve_irq(input irq_word_t w, output irq_result_t r);
		int best_p;
		int best_ln;
		int scan_end;
		int p;
		logic [3:0] lvl;
		r = NO_IRQ;
		case (w.req)
			REQ_SET_LINE: begin
				pend_code[w.line] = w.code;
				return 1'b0;
			end
			REQ_SET_IRL: begin
				for (int k = 0; k < 4; k++)
					pend_code[IRL_BASE + k] = w.pins[k] ? '0 : PIN_CODE[k];
				return 1'b0;
			end
			REQ_CHECK: ;
			default: return 1'b0;
		endcase
		if (w.blk || w.ds)
			return 1'b1;
		best_p = -1;
		best_ln = 0;
		scan_end = irl_indep ? NUM_LINES : IRL_BASE;
		for (int ln = 0; ln < scan_end; ln++) begin
			p = int'(line_prio(ln));
			if (p > w.mask && pend_code[ln] != 0 && p > best_p) begin
				best_p = p;
				best_ln = ln;
			end
		end
		if (!irl_indep) begin
			for (int k = 0; k < 4; k++)
				lvl[k] = (pend_code[IRL_BASE + k] != 0);
			lvl = ~lvl;
			p = 15 - int'(lvl);
			// idle bus at level 15; an ordinary line wins an equal priority
			if (lvl != 4'hF && p > best_p && p > w.mask) begin
				for (int k = 0; k < 4; k++)
					pend_code[IRL_BASE + k] = '0;
				r.taken = 1'b1;
				r.code = 12'h200 + 12'h20 * lvl;
				r.prio = PRIO_W'(p);
				r.irl = 1'b1;
				return 1'b1;
			end
		end
		if (best_p >= 0) begin
			r.taken = 1'b1;
			r.code = pend_code[best_ln];
			r.prio = PRIO_W'(best_p);
			r.line = LINE_W'(best_ln);
			pend_code[best_ln] = '0;
		end
		return 1'b1;
	endfunction

	task automatic send_word(input irq_word_t w, input bit typed, input irq_result_t exp_r,
			input bit may_idle);
		irq_result_t r;
		bit makes;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= w.req;
		line_index <= w.line;
		event_code_in <= w.code;
		irl_pins <= w.pins;
		interrupt_mask <= w.mask;
		block_bit <= w.blk;
		in_delay_slot <= w.ds;
		do @(posedge clk); while (busy);
		makes = serve_irq(w, r);
		if (makes)
			pending_irqs.push_back(typed ? exp_r : r);
		words_sent++;
		@(negedge clk);
	endtask

	// Hold start low until every result is back, then let a set word finish.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_irqs.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_IPR_A, REG_IPR_B, REG_IPR_C, REG_IPR_D: prio_reg[2'(idx)] = data;
			REG_INDEP_IRL: irl_indep = data[0];
			default: ;
		endcase
	endtask

	task automatic add_word(input req_t rq, input int ln, input int code, input int pins,
			input int mask, input bit blk, input bit ds, input bit typed, input irq_result_t w);
		dir_row_t row;
		row.is_reg = 1'b0;
		row.word = {rq, ln[3:0], code[11:0], pins[3:0], mask[3:0], blk, ds};
		row.typed = typed;
		row.want = w;
		row.reg_idx = REG_IPR_A;
		row.reg_data = '0;
		dir_rows.push_back(row);
	endtask

	task automatic add_reg(input cfg_reg_t idx, input int data);
		dir_row_t row;
		row.is_reg = 1'b1;
		row.word = '0;
		row.typed = 1'b0;
		row.want = NO_IRQ;
		row.reg_idx = idx;
		row.reg_data = data[15:0];
		dir_rows.push_back(row);
	endtask

	function automatic irq_word_t rand_word();
		irq_word_t w;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 38) w.req = REQ_SET_LINE;
		else if (sel < 53) w.req = REQ_SET_IRL;
		else if (sel < 95) w.req = REQ_CHECK;
		else w.req = REQ_NONE;
		w.line = LINE_W'($urandom_range(0, 15));
		sel = $urandom_range(0, 19);
		w.code = (sel < 2) ? 12'h000 : (sel == 2) ? 12'hFFF : CODE_W'($urandom_range(0, 4095));
		w.pins = ($urandom_range(0, 4) == 0) ? 4'hF : 4'($urandom_range(0, 15));
		w.mask = ($urandom_range(0, 2) == 0) ? 4'd0 : PRIO_W'($urandom_range(0, 15));
		w.blk = ($urandom_range(0, 9) == 0);
		w.ds = ($urandom_range(0, 9) == 0);
		return w;
	endfunction

	initial begin
		irq_word_t w;
		int counted;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_NONE;
		line_index = '0;
		event_code_in = '0;
		irl_pins = 4'hF;
		interrupt_mask = '0;
		block_bit = 1'b0;
		in_delay_slot = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IPR_A;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		words_sent = 0;
		results_seen = 0;
		taken_seen = 0;
		irl_wins = 0;
		settings_used = 1;
		for (int i = 0; i < NUM_LINES; i++) pend_code[i] = '0;
		for (int i = 0; i < 4; i++) prio_reg[i] = '0;
		irl_indep = 1'b0;

		// reset defaults: all priorities zero, encoded IRL bus
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 1, NO_IRQ);
		add_word(REQ_SET_LINE, 0, 'hFFF, 4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  1, 0, 1, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 1, 1, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 1, NO_IRQ);
		add_word(REQ_NONE,     9, 'hABC, 4'h0, 0,  0, 0, 0, NO_IRQ);
		add_reg(REG_IPR_A, 'hFFFF);
		add_reg(REG_IPR_B, 'h0001);
		add_reg(REG_IPR_C, 'h8421);
		add_reg(REG_IPR_D, 'hFFFF);
		add_reg(REG_INDEP_IRL, 0);
		add_word(REQ_SET_LINE, 3,  'h001, 4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_SET_LINE, 15, 'h123, 4'hF, 0,  0, 0, 0, NO_IRQ);
		// lines 0 and 3 tie at fifteen: lowest line first
		add_word(REQ_CHECK,    0, 0,     4'hF, 14, 0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 14, 0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 15, 0, 0, 1, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_SET_IRL,  0, 0,     4'h0, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_SET_LINE, 4, 'h555, 4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 1, IRL_TOP);
		add_word(REQ_SET_IRL,  0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		// ordinary line at priority one against IRL level fourteen
		add_word(REQ_SET_IRL,  0, 0,     4'hE, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_SET_LINE, 4, 'h777, 4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		add_reg(REG_INDEP_IRL, 1);
		add_reg(REG_IPR_D, 'h1234);
		add_word(REQ_SET_IRL,  0, 0,     4'hA, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);
		add_word(REQ_CHECK,    0, 0,     4'hF, 0,  0, 0, 0, NO_IRQ);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].is_reg) begin
				if (i == 0 || !dir_rows[i - 1].is_reg) begin
					wait_idle();
					settings_used++;
				end
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
			end else begin
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, 1'b1);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			settings_used++;
			for (int r = 0; r < 4; r++) begin
				case (ph)
					0: write_reg(cfg_reg_t'(r), 16'hFFFF);
					1: write_reg(cfg_reg_t'(r), 16'h0000);
					default: write_reg(cfg_reg_t'(r), 16'($urandom_range(0, 65535)));
				endcase
			end
			write_reg(REG_INDEP_IRL, 16'((ph < 2) ? ph : $urandom_range(0, 1)));
			counted = 0;
			while (counted < RAND_ITEMS / RAND_PHASES) begin
				w = rand_word();
				send_word(w, 1'b0, NO_IRQ, ph != RAND_PHASES - 1);
				if (w.req != REQ_NONE) counted++;
			end
		end

		start <= 1'b0;
		while (pending_irqs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d words under %0d register settings in %0d cycles.",
			words_sent, settings_used, cycles);
		$display("Checked %0d results: %0d interrupts taken, %0d from the IRL level, %0d errors.",
			results_seen, taken_seen, irl_wins, errors);
		if (errors == 0)
			$display("interrupt_priority_select test passed");
		else
			$display("interrupt_priority_select test failed");
		$finish;
	end

endmodule
